// ===== hw/rtl/ryuv_pkg.sv =====
// Shared types and constants for the RGB to YUV 4:2:0 converter.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package ryuv_pkg;

    // Configuration register file
    localparam int unsigned FW_W   = 13;
    localparam int unsigned APB_AW = 2;
    localparam int unsigned APB_DW = 32;

    localparam logic [FW_W-1:0]   FW_RESET         = 13'd640;
    localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH = 2'd0;

    localparam int unsigned SUM_W = 9;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic   frame_start;
        pixel_t pix;
    } in_item_t;

    // Three horizontal pair sums; also the line store word
    typedef struct packed {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
    } pair_sums_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma;
        pair_sums_t sums;
    } pair_item_t;

endpackage

// ===== hw/rtl/rgb_to_yuv420_converter.sv =====
// An s_ transfer passes the input reg, stage 1 and the result reg, in that order, before m_tvalid rises.
// Throughput: one pixel per cycle sustained while m_tready stays high; the line store is touched once per
//   pixel pair through its single port, alternating write (even row) and read (odd row).
// Reset: synchronous, aresetn low clears pipeline valids, row/column position and
//   sets frame_width to 640. The line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Pixel input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                         s_tuser,   // frame_start

    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // luma[7:0], blue_diff[15:8], red_diff[23:16]
    output logic                         m_tuser,   // chroma_valid

    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ryuv_pkg::APB_AW-1:0]  paddr,
    input  logic [ryuv_pkg::APB_DW-1:0]  pwdata,
    output logic [ryuv_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    logic [ryuv_pkg::FW_W-1:0] frame_width;

    // Input register
    logic                  in_valid_reg;
    ryuv_pkg::in_item_t    in_item_reg;

    // Stage 1 to stage 2
    logic                  pair_in_ready;
    logic                  pair_valid;
    ryuv_pkg::pair_item_t  pair_item;
    ryuv_pkg::pair_sums_t  line_data;
    logic                  chroma_in_ready;

    ryuv_apb u_apb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_width (frame_width)
    );

    // Input register takes a new transfer whenever it is empty or drains
    assign s_tready = !in_valid_reg || pair_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.frame_start <= s_tuser;
            in_item_reg.pix.red     <= s_tdata[7:0];
            in_item_reg.pix.green   <= s_tdata[15:8];
            in_item_reg.pix.blue    <= s_tdata[23:16];
        end
    end

    // Position, pair sums, luma and the line store
    ryuv_pair #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pair (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_width (frame_width),
        .in_valid    (in_valid_reg),
        .in_item     (in_item_reg),
        .in_ready    (pair_in_ready),
        .out_valid   (pair_valid),
        .out_item    (pair_item),
        .line_data   (line_data),
        .out_ready   (chroma_in_ready)
    );

    // 2x2 average, U/V and the result register
    ryuv_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pair_valid),
        .in_item   (pair_item),
        .line_data (line_data),
        .in_ready  (chroma_in_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A draining output must never back-pressure the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // Luma stays in studio range
    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] >= 8'd16) && (m_tdata[7:0] <= 8'd235))
        else $error("luma out of range");

    // Chroma fields are zero on pixels that do not close a block
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[23:8] == 16'd0))
        else $error("chroma fields set without chroma_valid");

    // Chroma stays in studio range when valid
    a_chroma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[15:8] >= 8'd16) && (m_tdata[15:8] <= 8'd240)
                                  && (m_tdata[23:16] >= 8'd16) && (m_tdata[23:16] <= 8'd240))
        else $error("chroma out of range");

endmodule

// ===== hw/rtl/ryuv_apb.sv =====
// APB register file for the converter: holds frame_width.
// Depends on ryuv_pkg.
`timescale 1ns / 1ps

module ryuv_apb (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ryuv_pkg::APB_AW-1:0]      paddr,
    input  logic [ryuv_pkg::APB_DW-1:0]      pwdata,
    output logic [ryuv_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output logic [ryuv_pkg::FW_W-1:0]        frame_width
);

    logic [ryuv_pkg::FW_W-1:0] frame_width_reg;
    logic                      wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr == ryuv_pkg::ADDR_FRAME_WIDTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= ryuv_pkg::FW_RESET;
        end else if (wr_hit) begin
            frame_width_reg <= pwdata[ryuv_pkg::FW_W-1:0];
        end
    end

    always_comb begin
        if (paddr == ryuv_pkg::ADDR_FRAME_WIDTH) begin
            prdata = ryuv_pkg::APB_DW'(frame_width_reg);
        end else begin
            prdata = '0;
        end
    end

    assign frame_width = frame_width_reg;

endmodule

// ===== hw/rtl/ryuv_pair.sv =====
// Stage 1: raster position, held even pixel, horizontal pair sums, luma,
// and the line store of even-row pair sums. Depends on ryuv_pkg.
`timescale 1ns / 1ps

module ryuv_pair #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ryuv_pkg::FW_W-1:0]  frame_width,
    input  logic                       in_valid,
    input  ryuv_pkg::in_item_t         in_item,
    output logic                       in_ready,
    output logic                       out_valid,
    output ryuv_pkg::pair_item_t       out_item,
    output ryuv_pkg::pair_sums_t       line_data,
    input  logic                       out_ready
);

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned COL_W      = IDX_W + 1;
    localparam int unsigned WID_W      = COL_W + 1;
    localparam int unsigned CMP_W      = (WID_W > ryuv_pkg::FW_W) ? WID_W : ryuv_pkg::FW_W;
    localparam logic [CMP_W-1:0] MAX_EVEN = CMP_W'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [CMP_W-1:0] MIN_W    = CMP_W'(2);

    localparam logic [15:0] Y_KR    = 16'd66;
    localparam logic [15:0] Y_KG    = 16'd129;
    localparam logic [15:0] Y_KB    = 16'd25;
    localparam logic [15:0] Y_ROUND = 16'd128;
    localparam logic [7:0]  Y_OFS   = 8'd16;

    logic [COL_W-1:0]      col_reg;
    logic                  odd_reg;
    ryuv_pkg::pixel_t      held_reg;
    logic                  valid_reg;
    ryuv_pkg::pair_item_t  item_reg;
    ryuv_pkg::pair_sums_t  line_data_reg;
    ryuv_pkg::pair_sums_t  line_mem [LINE_DEPTH];

    logic [CMP_W-1:0]      fw_even;
    logic [CMP_W-1:0]      eff_width;
    logic [COL_W-1:0]      col;
    logic                  odd;
    logic [WID_W-1:0]      col_inc;
    logic                  row_end;
    logic [IDX_W-1:0]      idx;
    logic                  advance;
    ryuv_pkg::pixel_t      px;
    ryuv_pkg::pair_sums_t  sums;
    logic [15:0]           y_sum;
    logic [7:0]            luma;

    // Clamp the configured width to an even value in 2..MAX_WIDTH
    always_comb begin
        fw_even = CMP_W'({frame_width[ryuv_pkg::FW_W-1:1], 1'b0});
        if (fw_even < MIN_W) begin
            eff_width = MIN_W;
        end else if (fw_even > MAX_EVEN) begin
            eff_width = MAX_EVEN;
        end else begin
            eff_width = fw_even;
        end
    end

    assign px      = in_item.pix;
    assign col     = in_item.frame_start ? '0 : col_reg;
    assign odd     = in_item.frame_start ? 1'b0 : odd_reg;
    assign col_inc = {1'b0, col} + WID_W'(1);
    assign row_end = CMP_W'(col_inc) >= eff_width;
    assign idx     = col[IDX_W:1];

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    assign sums.sum_r = {1'b0, held_reg.red}   + {1'b0, px.red};
    assign sums.sum_g = {1'b0, held_reg.green} + {1'b0, px.green};
    assign sums.sum_b = {1'b0, held_reg.blue}  + {1'b0, px.blue};

    assign y_sum = Y_KR * 16'(px.red) + Y_KG * 16'(px.green) + Y_KB * 16'(px.blue)
                   + Y_ROUND;
    assign luma  = y_sum[15:8] + Y_OFS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            odd_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (advance) begin
                col_reg <= row_end ? '0 : col_inc[COL_W-1:0];
                odd_reg <= odd ^ row_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (!col[0]) begin
                held_reg <= px;
            end
            item_reg.luma   <= luma;
            item_reg.chroma <= col[0] && odd;
            item_reg.sums   <= sums;
        end
    end

    // Single port: even rows write the pair sums, odd rows read them back
    always_ff @(posedge aclk) begin
        if (advance && col[0]) begin
            if (odd) begin
                line_data_reg <= line_mem[idx];
            end else begin
                line_mem[idx] <= sums;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign line_data = line_data_reg;

endmodule

// ===== hw/rtl/ryuv_chroma.sv =====
// Stage 2: 2x2 averages, U/V products and the result register.
// Depends on ryuv_pkg.
`timescale 1ns / 1ps

module ryuv_chroma (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  ryuv_pkg::pair_item_t  in_item,
    input  ryuv_pkg::pair_sums_t  line_data,
    output logic                  in_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tuser
);

    // Bias folds the +128 rounding and the +128 offset (128 + 128*256)
    localparam logic [15:0] C_BIAS = 16'd32896;
    localparam logic [15:0] U_KR   = 16'd38;
    localparam logic [15:0] U_KG   = 16'd74;
    localparam logic [15:0] U_KB   = 16'd112;
    localparam logic [15:0] V_KR   = 16'd112;
    localparam logic [15:0] V_KG   = 16'd94;
    localparam logic [15:0] V_KB   = 16'd18;

    logic        valid_reg;
    logic [7:0]  luma_reg;
    logic        chroma_reg;
    logic [7:0]  u_reg;
    logic [7:0]  v_reg;

    logic [9:0]  quad_r, quad_g, quad_b;
    logic [15:0] avg_r, avg_g, avg_b;
    logic [15:0] u_sum, v_sum;
    logic        advance;

    assign quad_r = {1'b0, in_item.sums.sum_r} + {1'b0, line_data.sum_r};
    assign quad_g = {1'b0, in_item.sums.sum_g} + {1'b0, line_data.sum_g};
    assign quad_b = {1'b0, in_item.sums.sum_b} + {1'b0, line_data.sum_b};
    assign avg_r  = 16'(quad_r[9:2]);
    assign avg_g  = 16'(quad_g[9:2]);
    assign avg_b  = 16'(quad_b[9:2]);

    // Both sums stay in 0..65535, so modular arithmetic floors exactly
    assign u_sum = C_BIAS + U_KB * avg_b - U_KR * avg_r - U_KG * avg_g;
    assign v_sum = C_BIAS + V_KR * avg_r - V_KG * avg_g - V_KB * avg_b;

    assign in_ready = !valid_reg || m_tready;
    assign advance  = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            luma_reg   <= in_item.luma;
            chroma_reg <= in_item.chroma;
            u_reg      <= in_item.chroma ? u_sum[15:8] : 8'd0;
            v_reg      <= in_item.chroma ? v_sum[15:8] : 8'd0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {v_reg, u_reg, luma_reg};
    assign m_tuser  = chroma_reg;

endmodule

// ===== dv/rgb_to_yuv420_converter_tb.sv =====
// Self-checking testbench for rgb_to_yuv420_converter: random raster frames on the pixel
// stream, results checked against an in-bench BT.601 4:2:0 predictor, width set over APB.
// Depends on ryuv_pkg and the converter RTL only.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_tb;

    localparam int unsigned MAX_PIXELS = 4096;
    localparam int unsigned LINE_DEPTH = MAX_PIXELS / 2;
    localparam int unsigned STALL_LIMIT = 2000;     // cycles without any transfer

    // One result transfer, split into its fields
    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] blue_difference;
        logic [7:0] red_difference;
    } yuv_t;

    // Receiver pacing; each pattern runs for a random stretch
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_pace_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata = '0;      // red[7:0], green[15:8], blue[23:16]
    logic                          s_tuser = 1'b0;    // frame_start
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [23:0]                   m_tdata;           // luma[7:0], blue_diff[15:8], red_diff[23:16]
    logic                          m_tuser;           // chroma_valid
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ryuv_pkg::APB_AW-1:0]   paddr = ryuv_pkg::ADDR_FRAME_WIDTH;
    logic [ryuv_pkg::APB_DW-1:0]   pwdata = '0;
    logic [ryuv_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    rgb_to_yuv420_converter #(
        .MAX_WIDTH (MAX_PIXELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    ryuv_pkg::in_item_t pending_pixels[$];   // filled by the sequence, drained by the driver
    yuv_t        expected_yuv[$];     // predicted results, oldest first
    int unsigned mismatch_count = 0;
    bit          s_taken = 1'b0;      // set at the edge that accepted s_tdata
    bit          tx_steady = 1'b0;    // sender offers back to back, no gaps
    int unsigned tx_burst_left = 0;
    int unsigned tx_gap_left = 0;
    int unsigned rx_hold_left = 0;    // long hold-off requested by the sequence
    int unsigned rx_run_left = 0;
    rx_pace_t    rx_mode = RX_OPEN;
    int unsigned stall_cycles = 0;

    // Predictor state: mirrors the converter's row/column tracking and line store
    logic [ryuv_pkg::FW_W-1:0] cur_width = ryuv_pkg::FW_RESET;
    int unsigned               col_pos = 0;
    bit                        on_odd_row = 1'b0;
    ryuv_pkg::pixel_t          held_rgb = '0;
    ryuv_pkg::pair_sums_t      line_sums [LINE_DEPTH];

    // Width actually used: even, clamped to 2..MAX_PIXELS
    function automatic int unsigned effective_width(logic [ryuv_pkg::FW_W-1:0] w);
        int unsigned e;
        e = w & 13'h1FFE;
        if (e < 2) e = 2;
        if (e > MAX_PIXELS) e = MAX_PIXELS;
        return e;
    endfunction

    // Chroma term from block averages; the +128*256 bias keeps the shift a true floor
    function automatic logic [7:0] chroma_term(int kr, int kg, int kb, int r, int g, int b);
        int t;
        t = kr * r + kg * g + kb * b + 128 + 128 * 256;
        if (t < 0) t = 0;
        return 8'(t >>> 8);
    endfunction

    // Advances the predictor by one accepted pixel and returns its result
    function automatic yuv_t convert_pixel(ryuv_pkg::in_item_t it);
        int unsigned width, r, g, b, sr, sg, sb, idx;
        int          ar, ag, ab;
        yuv_t        res;
        width = effective_width(cur_width);
        r = it.pix.red;
        g = it.pix.green;
        b = it.pix.blue;
        res = '0;
        if (it.frame_start) begin
            col_pos = 0;
            on_odd_row = 1'b0;
        end
        res.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
        if (col_pos[0] == 1'b0) begin
            held_rgb = it.pix;
        end else begin
            idx = (col_pos >> 1) % LINE_DEPTH;
            sr = held_rgb.red + r;
            sg = held_rgb.green + g;
            sb = held_rgb.blue + b;
            if (!on_odd_row) begin
                line_sums[idx] = {9'(sr), 9'(sg), 9'(sb)};
            end else begin
                ar = (sr + line_sums[idx].sum_r) >> 2;
                ag = (sg + line_sums[idx].sum_g) >> 2;
                ab = (sb + line_sums[idx].sum_b) >> 2;
                res.blue_difference = chroma_term(-38, -74, 112, ar, ag, ab);
                res.red_difference = chroma_term(112, -94, -18, ar, ag, ab);
                res.chroma_valid = 1'b1;
            end
        end
        col_pos++;
        if (col_pos >= width) begin
            col_pos = 0;
            on_odd_row = !on_odd_row;
        end
        return res;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: predict on input transfers, check output transfers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_ports
        yuv_t               want;
        ryuv_pkg::in_item_t seen;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen = {s_tuser, s_tdata};
                expected_yuv.insert(expected_yuv.size(), convert_pixel(seen));
                s_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_yuv.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result transfer, expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_yuv[0];
                    expected_yuv.delete(0);
                    check_field("luma", want.luma, m_tdata[7:0]);
                    check_field("chroma_valid", want.chroma_valid, m_tuser);
                    check_field("blue_difference", want.blue_difference, m_tdata[15:8]);
                    check_field("red_difference", want.red_difference, m_tdata[23:16]);
                end
            end
        end
    end

    // Watchdog: work outstanding but no transfer on either side for too long
    always @(posedge aclk) begin
        if ((pending_pixels.size() != 0 || s_tvalid || expected_yuv.size() != 0)
                && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("rgb_to_yuv420_converter regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: bursts of random length with random gaps, changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_pixels
        logic               nxt_valid;
        ryuv_pkg::in_item_t nxt;
        nxt_valid = s_tvalid;
        if (s_taken) begin
            nxt_valid = 1'b0;
            s_taken = 1'b0;
        end
        if (!nxt_valid && aresetn) begin
            if (tx_gap_left > 0 && !tx_steady) begin
                tx_gap_left--;
            end else if (pending_pixels.size() != 0) begin
                nxt = pending_pixels[0];
                pending_pixels.delete(0);
                s_tdata <= nxt.pix;
                s_tuser <= nxt.frame_start;
                nxt_valid = 1'b1;
                if (tx_burst_left > 0) tx_burst_left--;
                if (tx_burst_left == 0) begin
                    tx_burst_left = $urandom_range(1, 40);
                    // a quarter of the bursts follow on without a gap
                    tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Result receiver: its own stall pattern, plus the long hold-off on request
    always @(negedge aclk) begin : pace_results
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_run_left == 0) begin
                rx_mode = rx_pace_t'($urandom_range(0, 3));
                rx_run_left = $urandom_range(16, 96);
            end else begin
                rx_run_left--;
            end
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                RX_HALF:  m_tready <= 1'($urandom_range(0, 1));
                default:  m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Components lean toward 0 and 255 so the chroma extremes come up often
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_pixel(bit fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        ryuv_pkg::in_item_t it;
        it.frame_start = fs;
        it.pix.red = r;
        it.pix.green = g;
        it.pix.blue = b;
        pending_pixels.insert(pending_pixels.size(), it);
    endtask

    // Uniform 2x2 block at width 2
    task automatic push_block(bit fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        push_pixel(fs, r, g, b);
        repeat (3) push_pixel(1'b0, r, g, b);
    endtask

    // Random pixels in raster order; noisy runs get stray frame starts mid-frame
    task automatic push_run(int unsigned count, bit first_start, bit noisy);
        bit fs;
        for (int unsigned i = 0; i < count; i++) begin
            fs = (i == 0) ? first_start : (noisy && $urandom_range(0, 63) == 0);
            push_pixel(fs, pick_level(), pick_level(), pick_level());
        end
    endtask

    // Random whole frames of 1..3 rows (odd heights included) until the quota is met
    task automatic push_frames(int unsigned w, int quota);
        int unsigned rows;
        while (quota > 0) begin
            rows = $urandom_range(1, 3);
            push_run(rows * w, 1'b1, 1'b1);
            quota -= rows * w;
        end
    endtask

    // Sender holds until every predicted result has come back, then the pipe settles
    task automatic drain_results();
        while (pending_pixels.size() != 0 || s_tvalid || expected_yuv.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // APB write of frame_width, then read back; block must be idle
    task automatic program_frame_width(logic [ryuv_pkg::FW_W-1:0] value);
        logic [ryuv_pkg::APB_DW-1:0] word;
        word = $urandom;
        word[ryuv_pkg::FW_W-1:0] = value;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ryuv_pkg::ADDR_FRAME_WIDTH;
        pwdata <= word;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        cur_width = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("frame_width readback", value, prdata[ryuv_pkg::FW_W-1:0]);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_regression
        logic [ryuv_pkg::FW_W-1:0] phase_widths [12] = '{13'd0, 13'd1, 13'd7, 13'd4, 13'd16,
                                                         13'd10, 13'd30, 13'd2, 13'd12, 13'd8,
                                                         13'd14, 13'd6};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset width (640): rows never complete here, luma only
        @(posedge aclk);
        push_run(20, 1'b0, 1'b0);
        drain_results();

        // Directed blocks at the narrowest width
        program_frame_width(13'd2);
        @(posedge aclk);
        push_block(1'b1, 8'd0, 8'd0, 8'd0);         // black: Y floor
        push_block(1'b0, 8'd255, 8'd255, 8'd255);   // white: Y ceiling
        push_block(1'b0, 8'd255, 8'd0, 8'd0);       // red: V top
        push_block(1'b0, 8'd0, 8'd0, 8'd255);       // blue: U top
        push_block(1'b0, 8'd255, 8'd255, 8'd0);     // yellow: U bottom
        // cyan-ish block with uneven sums, averaging rounds down
        push_pixel(1'b0, 8'd0, 8'd255, 8'd255);
        push_pixel(1'b0, 8'd1, 8'd255, 8'd254);
        push_pixel(1'b0, 8'd0, 8'd254, 8'd255);
        push_pixel(1'b0, 8'd1, 8'd255, 8'd255);
        drain_results();

        // Random frames over several widths, out-of-range values among them
        foreach (phase_widths[i]) begin
            program_frame_width(phase_widths[i]);
            @(posedge aclk);
            push_frames(effective_width(phase_widths[i]), 12);
            drain_results();
        end

        // Long receiver hold-off while the sender streams: input side must back up
        program_frame_width(13'd24);
        @(posedge aclk);
        tx_steady = 1'b1;
        rx_hold_left = 300;
        push_run(96, 1'b1, 1'b1);
        drain_results();
        tx_steady = 1'b0;

        // Sender pauses mid-frame with the even row stored, odd row resumes after
        program_frame_width(13'd10);
        @(posedge aclk);
        push_run(16, 1'b1, 1'b0);
        drain_results();
        push_run(24, 1'b0, 1'b0);
        drain_results();

        // Narrower width taken mid even row: row ends at once, odd row reads stored pairs
        program_frame_width(13'd16);
        @(posedge aclk);
        push_run(12, 1'b1, 1'b0);
        drain_results();
        program_frame_width(13'd6);
        @(posedge aclk);
        push_run(18, 1'b0, 1'b0);
        drain_results();

        // Above the maximum: clamps to full width
        program_frame_width(13'd8191);
        @(posedge aclk);
        push_run(40, 1'b1, 1'b1);
        drain_results();

        if (mismatch_count == 0) begin
            $display("rgb_to_yuv420_converter regression: pass");
        end else begin
            $display("rgb_to_yuv420_converter regression: fail");
        end
        $finish;
    end

endmodule
